// ===== src/bms_pkg.sv =====
// Shared types, constants and ROM contents for the buzzer melody sequencer.
package bms_pkg;

   // Command codes carried in req_op.
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_PLAY = 2'd1;
   localparam logic [1:0] OP_TONE = 2'd2;
   localparam logic [1:0] OP_STOP = 2'd3;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 24;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DURATION_UNIT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TIMER_CLOCK   = 1'd1;

   // Field widths.
   localparam int UNIT_WIDTH        = 8;
   localparam int TIMER_CLOCK_WIDTH = 24;
   localparam int FREQ_WIDTH        = 16;
   localparam int TIME_WIDTH        = 16;
   localparam int PERIOD_WIDTH      = 16;
   localparam int HALF_WIDTH        = 15;
   localparam int MELODY_WIDTH      = 3;
   localparam int POSITION_WIDTH    = 3;
   localparam int NOTE_WIDTH        = 4;
   localparam int DURATION_WIDTH    = 5;

   // Reset values of the configuration registers.
   localparam logic [UNIT_WIDTH-1:0]        DURATION_UNIT_RESET = 8'd10;
   localparam logic [TIMER_CLOCK_WIDTH-1:0] TIMER_CLOCK_RESET   = 24'd1000000;

   // Melody and note table sizes.
   localparam int MELODY_COUNT    = 5;
   localparam int NOTE_TABLE_SIZE = 16;
   localparam int MELODY_PAIRS    = 5;

   // Period clamp limits.
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_MIN = 16'd2;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = 16'd65535;

   // One quotient bit per divider step.
   localparam int DIV_STEPS = TIMER_CLOCK_WIDTH;

   typedef struct packed {
      logic [NOTE_WIDTH-1:0]     note;
      logic [DURATION_WIDTH-1:0] duration;
   } pair_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic accept;
      logic div_start;
      logic div_commit;
      logic publish;
   } ctrl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic need_div;
      logic div_done;
   } ctrl_status_type;

   function automatic logic [FREQ_WIDTH-1:0] note_to_hz(input logic [NOTE_WIDTH-1:0] note);
      logic [FREQ_WIDTH-1:0] freq;
      case (note)
         4'd1:    freq = 16'd262;
         4'd2:    freq = 16'd294;
         4'd3:    freq = 16'd330;
         4'd4:    freq = 16'd349;
         4'd5:    freq = 16'd392;
         4'd6:    freq = 16'd440;
         4'd7:    freq = 16'd494;
         4'd8:    freq = 16'd523;
         4'd9:    freq = 16'd587;
         4'd10:   freq = 16'd659;
         4'd11:   freq = 16'd698;
         4'd12:   freq = 16'd784;
         4'd13:   freq = 16'd880;
         4'd14:   freq = 16'd988;
         4'd15:   freq = 16'd1047;
         default: freq = 16'd0;
      endcase
      return freq;
   endfunction

   function automatic logic [POSITION_WIDTH-1:0] melody_length(
      input logic [MELODY_WIDTH-1:0] sel);
      logic [POSITION_WIDTH-1:0] len;
      case (sel)
         3'd0:    len = 3'd4;
         3'd1:    len = 3'd2;
         3'd2:    len = 3'd3;
         3'd3:    len = 3'd5;
         3'd4:    len = 3'd2;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic pair_type melody_pair(input logic [MELODY_WIDTH-1:0] sel,
                                            input logic [POSITION_WIDTH-1:0] pos);
      pair_type pair;
      case ({sel, pos})
         {3'd0, 3'd0}: pair = '{note: 4'd8,  duration: 5'd8};
         {3'd0, 3'd1}: pair = '{note: 4'd10, duration: 5'd8};
         {3'd0, 3'd2}: pair = '{note: 4'd12, duration: 5'd8};
         {3'd0, 3'd3}: pair = '{note: 4'd15, duration: 5'd16};
         {3'd1, 3'd0}: pair = '{note: 4'd12, duration: 5'd6};
         {3'd1, 3'd1}: pair = '{note: 4'd15, duration: 5'd12};
         {3'd2, 3'd0}: pair = '{note: 4'd6,  duration: 5'd10};
         {3'd2, 3'd1}: pair = '{note: 4'd0,  duration: 5'd3};
         {3'd2, 3'd2}: pair = '{note: 4'd4,  duration: 5'd20};
         {3'd3, 3'd0}: pair = '{note: 4'd15, duration: 5'd7};
         {3'd3, 3'd1}: pair = '{note: 4'd0,  duration: 5'd5};
         {3'd3, 3'd2}: pair = '{note: 4'd15, duration: 5'd7};
         {3'd3, 3'd3}: pair = '{note: 4'd0,  duration: 5'd5};
         {3'd3, 3'd4}: pair = '{note: 4'd15, duration: 5'd7};
         {3'd4, 3'd0}: pair = '{note: 4'd13, duration: 5'd5};
         {3'd4, 3'd1}: pair = '{note: 4'd15, duration: 5'd28};
         default:      pair = '{note: 4'd0,  duration: 5'd0};
      endcase
      return pair;
   endfunction

endpackage

// ===== src/buzzer_melody_sequencer_core.sv =====
// Buzzer melody sequencer: command and tick decoder driving a 50% square-wave tone timer.
// Each request transaction (a 1 ms tick, play, raw tone or stop) yields one response
// transaction with the timer settings and status after that item. An item that
// programs no new tone is loaded into the result register after acceptance. An item
// that programs a nonzero tone first runs the 24-step restoring divider that forms
// timer_clock_hz / frequency for the reload value, then commits the period and loads
// the result register. One item is in work at a time; the next request is accepted
// as soon as the result sits in the output register, even if the consumer has not yet
// taken it. Configuration writes through the csr_ port take effect on the next clock
// and are meant for idle periods.
module buzzer_melody_sequencer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [bms_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bms_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_op,
   input  logic [bms_pkg::MELODY_WIDTH-1:0]      req_melody_index,
   input  logic [bms_pkg::FREQ_WIDTH-1:0]        req_tone_freq_hz,
   input  logic [bms_pkg::TIME_WIDTH-1:0]        req_tone_duration_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_tone_enable,
   output logic [bms_pkg::PERIOD_WIDTH-1:0]      rsp_reload_value,
   output logic [bms_pkg::HALF_WIDTH-1:0]        rsp_compare_value,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_retuned
);

   bms_pkg::ctrl_cmd_type    cmd;
   bms_pkg::ctrl_status_type status;

   bms_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bms_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_op               (req_op),
      .req_melody_index     (req_melody_index),
      .req_tone_freq_hz     (req_tone_freq_hz),
      .req_tone_duration_ms (req_tone_duration_ms),
      .cmd                  (cmd),
      .status               (status),
      .rsp_tone_enable      (rsp_tone_enable),
      .rsp_reload_value     (rsp_reload_value),
      .rsp_compare_value    (rsp_compare_value),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_retuned          (rsp_retuned)
   );

endmodule

// ===== src/bms_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
module bms_divider (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [bms_pkg::TIMER_CLOCK_WIDTH-1:0]  dividend,
   input  logic [bms_pkg::FREQ_WIDTH-1:0]         divisor,
   output logic                                   done,
   output logic [bms_pkg::TIMER_CLOCK_WIDTH-1:0]  quotient
);

   localparam int QW = bms_pkg::TIMER_CLOCK_WIDTH;
   localparam int DW = bms_pkg::FREQ_WIDTH;
   localparam int CW = $clog2(bms_pkg::DIV_STEPS);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] divisor_ff, divisor_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          fits;

   always_comb begin
      trial = {rem_ff, quot_ff[QW-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[QW-2:0], fits};
         rem_in   = fits ? diff[DW-1:0] : trial[DW-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(bms_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== src/bms_datapath.sv =====
// Sequencer state, configuration registers, tone programming and result register.
module bms_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [bms_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bms_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   input  logic [1:0]                            req_op,
   input  logic [bms_pkg::MELODY_WIDTH-1:0]      req_melody_index,
   input  logic [bms_pkg::FREQ_WIDTH-1:0]        req_tone_freq_hz,
   input  logic [bms_pkg::TIME_WIDTH-1:0]        req_tone_duration_ms,
   input  bms_pkg::ctrl_cmd_type                 cmd,
   output bms_pkg::ctrl_status_type              status,
   output logic                                  rsp_tone_enable,
   output logic [bms_pkg::PERIOD_WIDTH-1:0]      rsp_reload_value,
   output logic [bms_pkg::HALF_WIDTH-1:0]        rsp_compare_value,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_retuned
);

   localparam int TW = bms_pkg::TIME_WIDTH;
   localparam int PW = bms_pkg::PERIOD_WIDTH;

   // Configuration.
   logic [bms_pkg::UNIT_WIDTH-1:0]        duration_unit_ff;
   logic [bms_pkg::TIMER_CLOCK_WIDTH-1:0] timer_clock_ff;

   // Sequencer state.
   logic [bms_pkg::MELODY_WIDTH-1:0]   melody_select_ff, melody_select_in;
   logic [bms_pkg::POSITION_WIDTH-1:0] note_position_ff, note_position_in;
   logic                               active_ff, active_in;
   logic                               sequence_mode_ff, sequence_mode_in;
   logic [TW-1:0]                      time_left_ff, time_left_in;
   logic                               enable_ff, enable_in;
   logic [PW-1:0]                      period_ff, period_in;
   logic [bms_pkg::HALF_WIDTH-1:0]     half_period_ff, half_period_in;
   logic                               retuned_ff, retuned_in;

   // Result register.
   logic                               out_enable_ff;
   logic [PW-1:0]                      out_period_ff;
   logic [bms_pkg::HALF_WIDTH-1:0]     out_half_ff;
   logic                               out_busy_ff;
   logic                               out_retuned_ff;

   // Decode of the current transaction.
   logic [TW-1:0]                      time_dec;
   logic                               play_ok;
   logic [bms_pkg::MELODY_WIDTH-1:0]   adv_sel;
   logic [bms_pkg::POSITION_WIDTH-1:0] adv_pos;
   logic                               adv_seq;
   logic                               adv_end;
   bms_pkg::pair_type                  pair;
   logic [bms_pkg::FREQ_WIDTH-1:0]     adv_freq;
   logic [TW-1:0]                      adv_time;
   logic                               do_advance;
   logic                               start_tone;
   logic [bms_pkg::FREQ_WIDTH-1:0]     tone_freq;

   // Divider and clamp.
   logic                                  div_done;
   logic [bms_pkg::TIMER_CLOCK_WIDTH-1:0] div_quotient;
   logic [PW-1:0]                         period_clamped;

   bms_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (timer_clock_ff),
      .divisor  (tone_freq),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_unit_ff <= bms_pkg::DURATION_UNIT_RESET;
         timer_clock_ff   <= bms_pkg::TIMER_CLOCK_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bms_pkg::REG_DURATION_UNIT:
               duration_unit_ff <= csr_write_data[bms_pkg::UNIT_WIDTH-1:0];
            bms_pkg::REG_TIMER_CLOCK:
               timer_clock_ff <= csr_write_data[bms_pkg::TIMER_CLOCK_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      time_dec = (time_left_ff == '0) ? '0 : time_left_ff - 1'b1;
      play_ok  = (32'(req_melody_index) < bms_pkg::MELODY_COUNT);

      // A play restarts the melody from its first pair; a tick continues it.
      adv_sel  = (req_op == bms_pkg::OP_PLAY) ? req_melody_index : melody_select_ff;
      adv_pos  = (req_op == bms_pkg::OP_PLAY) ? '0 : note_position_ff;
      adv_seq  = (req_op == bms_pkg::OP_PLAY) || sequence_mode_ff;
      pair     = bms_pkg::melody_pair(adv_sel, adv_pos);
      adv_end  = !adv_seq || (32'(adv_pos) >= bms_pkg::MELODY_PAIRS)
                 || (adv_pos >= bms_pkg::melody_length(adv_sel));
      adv_freq = (32'(pair.note) < bms_pkg::NOTE_TABLE_SIZE)
                 ? bms_pkg::note_to_hz(pair.note) : '0;
      adv_time = {{(TW - bms_pkg::DURATION_WIDTH){1'b0}}, pair.duration}
                 * {{(TW - bms_pkg::UNIT_WIDTH){1'b0}}, duration_unit_ff};

      melody_select_in = melody_select_ff;
      note_position_in = note_position_ff;
      active_in        = active_ff;
      sequence_mode_in = sequence_mode_ff;
      time_left_in     = time_left_ff;
      enable_in        = enable_ff;
      do_advance       = 1'b0;
      start_tone       = 1'b0;
      tone_freq        = '0;

      case (req_op)
         bms_pkg::OP_TICK: begin
            if (active_ff) begin
               time_left_in = time_dec;
               do_advance   = (time_dec == '0);
            end
         end
         bms_pkg::OP_PLAY: begin
            if (play_ok) begin
               melody_select_in = req_melody_index;
               note_position_in = '0;
               sequence_mode_in = 1'b1;
               active_in        = 1'b1;
               do_advance       = 1'b1;
            end
         end
         bms_pkg::OP_TONE: begin
            start_tone       = 1'b1;
            tone_freq        = req_tone_freq_hz;
            sequence_mode_in = 1'b0;
            note_position_in = '0;
            active_in        = 1'b1;
            time_left_in     = req_tone_duration_ms;
         end
         default: begin
            enable_in = 1'b0;
            active_in = 1'b0;
         end
      endcase

      if (do_advance) begin
         if (adv_end) begin
            enable_in = 1'b0;
            active_in = 1'b0;
         end else begin
            note_position_in = adv_pos + 1'b1;
            time_left_in     = adv_time;
            start_tone       = 1'b1;
            tone_freq        = adv_freq;
         end
      end

      // A zero frequency silences the output and leaves the period registers alone.
      if (start_tone && (tone_freq == '0)) begin
         enable_in = 1'b0;
      end

      status.need_div = start_tone && (tone_freq != '0);
      status.div_done = div_done;
   end

   always_comb begin
      if (div_quotient < {{(bms_pkg::TIMER_CLOCK_WIDTH - PW){1'b0}}, bms_pkg::PERIOD_MIN}) begin
         period_clamped = bms_pkg::PERIOD_MIN;
      end else if (div_quotient
                   > {{(bms_pkg::TIMER_CLOCK_WIDTH - PW){1'b0}}, bms_pkg::PERIOD_MAX}) begin
         period_clamped = bms_pkg::PERIOD_MAX;
      end else begin
         period_clamped = div_quotient[PW-1:0];
      end
      period_in      = period_clamped - 1'b1;
      half_period_in = period_clamped[PW-1:1];
      retuned_in     = cmd.div_commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         melody_select_ff <= '0;
         note_position_ff <= '0;
         active_ff        <= 1'b0;
         sequence_mode_ff <= 1'b0;
         time_left_ff     <= '0;
         enable_ff        <= 1'b0;
         period_ff        <= '0;
         half_period_ff   <= '0;
         retuned_ff       <= 1'b0;
      end else if (cmd.accept) begin
         melody_select_ff <= melody_select_in;
         note_position_ff <= note_position_in;
         active_ff        <= active_in;
         sequence_mode_ff <= sequence_mode_in;
         time_left_ff     <= time_left_in;
         enable_ff        <= enable_in;
         retuned_ff       <= 1'b0;
      end else if (cmd.div_commit) begin
         period_ff      <= period_in;
         half_period_ff <= half_period_in;
         enable_ff      <= 1'b1;
         retuned_ff     <= retuned_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_enable_ff  <= enable_ff;
         out_period_ff  <= period_ff;
         out_half_ff    <= half_period_ff;
         out_busy_ff    <= active_ff;
         out_retuned_ff <= retuned_ff;
      end
   end

   assign rsp_tone_enable   = out_enable_ff;
   assign rsp_reload_value  = out_period_ff;
   assign rsp_compare_value = out_half_ff;
   assign rsp_busy_res      = out_busy_ff;
   assign rsp_retuned       = out_retuned_ff;

endmodule

// ===== src/bms_controller.sv =====
// Controller state machine: sequences acceptance, division and result hand-off.
module bms_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  bms_pkg::ctrl_status_type  status,
   output bms_pkg::ctrl_cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_DIVIDE  = 3'b010,
      ST_PUBLISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.need_div) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIVIDE;
               end else begin
                  state_in = ST_PUBLISH;
               end
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.div_commit = 1'b1;
               state_in       = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            // The result register takes a new transaction once the old one has left.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== dv/buzzer_melody_sequencer_core_test.sv =====
// Self-checking testbench for the buzzer melody sequencer core.
module buzzer_melody_sequencer_core_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_PRINTED    = 40;
   localparam int LONG_HOLDOFF   = 300;

   typedef struct packed {
      logic                             tone_enable;
      logic [bms_pkg::PERIOD_WIDTH-1:0] reload_value;
      logic [bms_pkg::HALF_WIDTH-1:0]   compare_value;
      logic                             busy;
      logic                             retuned;
   } tone_status_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_write_enable;
   logic [bms_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [bms_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;
   logic                                req_valid;
   logic                                req_ready;
   logic [1:0]                          req_op;
   logic [bms_pkg::MELODY_WIDTH-1:0]    req_melody_index;
   logic [bms_pkg::FREQ_WIDTH-1:0]      req_tone_freq_hz;
   logic [bms_pkg::TIME_WIDTH-1:0]      req_tone_duration_ms;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic                                rsp_tone_enable;
   logic [bms_pkg::PERIOD_WIDTH-1:0]    rsp_reload_value;
   logic [bms_pkg::HALF_WIDTH-1:0]      rsp_compare_value;
   logic                                rsp_busy_res;
   logic                                rsp_retuned;

   buzzer_melody_sequencer_core dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_melody_index     (req_melody_index),
      .req_tone_freq_hz     (req_tone_freq_hz),
      .req_tone_duration_ms (req_tone_duration_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_tone_enable      (rsp_tone_enable),
      .rsp_reload_value     (rsp_reload_value),
      .rsp_compare_value    (rsp_compare_value),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_retuned          (rsp_retuned)
   );

   // Note frequencies and the melody tables, five pairs per melody.
   int unsigned scale_hz [16] = '{0, 262, 294, 330, 349, 392, 440, 494,
                                  523, 587, 659, 698, 784, 880, 988, 1047};
   int unsigned tune_length [8] = '{4, 2, 3, 5, 2, 0, 0, 0};
   int unsigned tune_note [40] = '{8, 10, 12, 15, 0,   12, 15, 0, 0, 0,
                                   6, 0, 4, 0, 0,      15, 0, 15, 0, 15,
                                   13, 15, 0, 0, 0,    0, 0, 0, 0, 0,
                                   0, 0, 0, 0, 0,      0, 0, 0, 0, 0};
   int unsigned tune_beats [40] = '{8, 8, 8, 16, 0,    6, 12, 0, 0, 0,
                                    10, 3, 20, 0, 0,   7, 5, 7, 5, 7,
                                    5, 28, 0, 0, 0,    0, 0, 0, 0, 0,
                                    0, 0, 0, 0, 0,     0, 0, 0, 0, 0};

   // Predictor state and its copy of the configuration.
   int unsigned                        unit_ms_cfg;
   int unsigned                        clock_hz_cfg;
   logic [bms_pkg::MELODY_WIDTH-1:0]   tune_sel;
   logic [bms_pkg::POSITION_WIDTH-1:0] tune_pos;
   logic                               playing;
   logic                               in_melody;
   logic [bms_pkg::TIME_WIDTH-1:0]     ms_left;
   logic                               pitch_on;
   logic [bms_pkg::PERIOD_WIDTH-1:0]   pitch_reload;
   logic [bms_pkg::HALF_WIDTH-1:0]     pitch_compare;

   tone_status_type status_q [$];
   int              mismatch_count = 0;
   int              result_count = 0;
   int              items_sent = 0;
   int              quiet_cycles = 0;
   int              holdoff_request = 0;
   logic            sender_idle;
   logic            receiver_idle;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic program_pitch(input int unsigned freq);
      int unsigned quotient;
      if (freq == 0) begin
         pitch_on = 1'b0;
         return 1'b0;
      end
      quotient = clock_hz_cfg / freq;
      if (quotient < 2) quotient = 2;
      if (quotient > 65535) quotient = 65535;
      quotient = quotient - 1;
      pitch_reload = quotient[bms_pkg::PERIOD_WIDTH-1:0];
      quotient = (quotient + 1) / 2;
      pitch_compare = quotient[bms_pkg::HALF_WIDTH-1:0];
      pitch_on = 1'b1;
      return 1'b1;
   endfunction

   // Loads the next melody pair, or stops once the melody or raw tone is over.
   function automatic logic next_note();
      int unsigned slot;
      int unsigned span;
      if (!in_melody || tune_pos >= bms_pkg::MELODY_PAIRS
          || tune_pos >= tune_length[tune_sel]) begin
         pitch_on = 1'b0;
         playing = 1'b0;
         return 1'b0;
      end
      slot = tune_sel * bms_pkg::MELODY_PAIRS + tune_pos;
      span = tune_beats[slot] * unit_ms_cfg;
      tune_pos = tune_pos + 3'd1;
      ms_left = span[bms_pkg::TIME_WIDTH-1:0];
      return program_pitch(tune_note[slot] < bms_pkg::NOTE_TABLE_SIZE
                           ? scale_hz[tune_note[slot]] : 0);
   endfunction

   function automatic tone_status_type predict_status(
      input logic [1:0]                       op,
      input logic [bms_pkg::MELODY_WIDTH-1:0] melody,
      input logic [bms_pkg::FREQ_WIDTH-1:0]   freq,
      input logic [bms_pkg::TIME_WIDTH-1:0]   ms);
      tone_status_type status;
      logic fresh;
      fresh = 1'b0;
      case (op)
         bms_pkg::OP_TICK: begin
            if (playing) begin
               if (ms_left != 0) ms_left = ms_left - 16'd1;
               if (ms_left == 0) fresh = next_note();
            end
         end
         bms_pkg::OP_PLAY: begin
            if (melody < bms_pkg::MELODY_COUNT) begin
               tune_sel = melody;
               tune_pos = '0;
               in_melody = 1'b1;
               playing = 1'b1;
               fresh = next_note();
            end
         end
         bms_pkg::OP_TONE: begin
            fresh = program_pitch(freq);
            in_melody = 1'b0;
            tune_pos = '0;
            playing = 1'b1;
            ms_left = ms;
         end
         default: begin
            pitch_on = 1'b0;
            playing = 1'b0;
         end
      endcase
      status.tone_enable = pitch_on;
      status.reload_value = pitch_reload;
      status.compare_value = pitch_compare;
      status.busy = playing;
      status.retuned = fresh;
      return status;
   endfunction

   function automatic int unsigned tune_units(input logic [bms_pkg::MELODY_WIDTH-1:0] sel);
      int unsigned total;
      int unsigned i;
      total = 0;
      for (i = 0; i < tune_length[sel]; i++)
         total += tune_beats[sel * bms_pkg::MELODY_PAIRS + i];
      return total;
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at result %0d: %s got %0h expected %0h",
                  result_count, what, got, want);
   endtask

   always @(posedge clock) begin : status_monitor
      tone_status_type want;
      if (reset) begin
         unit_ms_cfg = bms_pkg::DURATION_UNIT_RESET;
         clock_hz_cfg = bms_pkg::TIMER_CLOCK_RESET;
         tune_sel = '0;
         tune_pos = '0;
         playing = 1'b0;
         in_melody = 1'b0;
         ms_left = '0;
         pitch_on = 1'b0;
         pitch_reload = '0;
         pitch_compare = '0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == bms_pkg::REG_DURATION_UNIT)
               unit_ms_cfg = csr_write_data[bms_pkg::UNIT_WIDTH-1:0];
            else if (csr_index == bms_pkg::REG_TIMER_CLOCK)
               clock_hz_cfg = csr_write_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               flag_mismatch("result with nothing pending", 1, 0);
            end else begin
               want = status_q.pop_front();
               if (rsp_tone_enable !== want.tone_enable)
                  flag_mismatch("tone_enable", rsp_tone_enable, want.tone_enable);
               if (rsp_reload_value !== want.reload_value)
                  flag_mismatch("reload_value", rsp_reload_value, want.reload_value);
               if (rsp_compare_value !== want.compare_value)
                  flag_mismatch("compare_value", rsp_compare_value, want.compare_value);
               if (rsp_busy_res !== want.busy)
                  flag_mismatch("busy_res", rsp_busy_res, want.busy);
               if (rsp_retuned !== want.retuned)
                  flag_mismatch("retuned", rsp_retuned, want.retuned);
            end
            result_count++;
         end
         if (req_valid && req_ready)
            status_q.push_back(predict_status(req_op, req_melody_index, req_tone_freq_hz,
                                              req_tone_duration_ms));
      end
   end

   // A long quiet stretch means the block is hung.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result consumer: short random stalls, or one long hold-off on request.
   initial begin : result_sink
      int span;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request != 0) begin
            span = holdoff_request;
            holdoff_request = 0;
            rsp_ready = 1'b0;
            repeat (span - 1) @(negedge clock);
         end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   function automatic logic [15:0] any16();
      logic [31:0] r;
      r = $urandom;
      return r[15:0];
   endfunction

   function automatic logic [15:0] pick16(input int unsigned lo, input int unsigned hi);
      logic [31:0] r;
      r = $urandom_range(hi, lo);
      return r[15:0];
   endfunction

   function automatic logic [bms_pkg::MELODY_WIDTH-1:0] any_melody();
      logic [31:0] r;
      r = $urandom;
      return r[bms_pkg::MELODY_WIDTH-1:0];
   endfunction

   function automatic logic [1:0] any_op();
      logic [31:0] r;
      r = $urandom;
      return r[1:0];
   endfunction

   task automatic send_item(input logic [1:0]                       op,
                            input logic [bms_pkg::MELODY_WIDTH-1:0] melody,
                            input logic [bms_pkg::FREQ_WIDTH-1:0]   freq,
                            input logic [bms_pkg::TIME_WIDTH-1:0]   ms);
      if (sender_idle && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_op = op;
      req_melody_index = melody;
      req_tone_freq_hz = freq;
      req_tone_duration_ms = ms;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(bms_pkg::OP_TICK, any_melody(), any16(), any16());
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bms_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [bms_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic configure(input logic [bms_pkg::UNIT_WIDTH-1:0] unit,
                            input logic [bms_pkg::TIMER_CLOCK_WIDTH-1:0] hz);
      wait_drained();
      write_csr(bms_pkg::REG_DURATION_UNIT, {16'd0, unit});
      write_csr(bms_pkg::REG_TIMER_CLOCK, hz);
   endtask

   task automatic test_directed_melodies();
      send_ticks(1);
      send_item(bms_pkg::OP_PLAY, 3'd0, 16'd0, 16'd0);
      send_ticks(1);
      send_item(bms_pkg::OP_STOP, 3'd7, 16'hFFFF, 16'hFFFF);
      send_item(bms_pkg::OP_PLAY, 3'd1, 16'd0, 16'd0);
      send_item(bms_pkg::OP_PLAY, 3'd2, 16'd0, 16'd0);
      send_item(bms_pkg::OP_PLAY, 3'd3, 16'd0, 16'd0);
      send_item(bms_pkg::OP_PLAY, 3'd4, 16'd0, 16'd0);
      // Indices past the last melody must leave the running melody alone.
      send_item(bms_pkg::OP_PLAY, 3'd5, 16'd0, 16'd0);
      send_item(bms_pkg::OP_PLAY, 3'd6, 16'd0, 16'd0);
      send_item(bms_pkg::OP_PLAY, 3'd7, 16'd0, 16'd0);
      send_item(bms_pkg::OP_STOP, 3'd0, 16'd0, 16'd0);
   endtask

   task automatic test_directed_tones();
      send_item(bms_pkg::OP_TONE, 3'd0, 16'd0, 16'd3);
      send_ticks(3);
      send_item(bms_pkg::OP_TONE, 3'd0, 16'd440, 16'd0);
      send_ticks(1);
      send_item(bms_pkg::OP_TONE, 3'd0, 16'hFFFF, 16'hFFFF);
      send_item(bms_pkg::OP_TONE, 3'd0, 16'd1, 16'd1);
      send_ticks(1);
      send_item(bms_pkg::OP_STOP, 3'd0, 16'd0, 16'd0);
      send_ticks(1);
   endtask

   task automatic test_register_extremes();
      configure(8'd0, 24'd0);
      send_item(bms_pkg::OP_TONE, 3'd0, 16'd440, 16'd2);
      send_item(bms_pkg::OP_PLAY, 3'd4, 16'd0, 16'd0);
      send_ticks(3);
      configure(8'hFF, 24'hFFFFFF);
      send_item(bms_pkg::OP_TONE, 3'd0, 16'd1, 16'd5);
      send_item(bms_pkg::OP_TONE, 3'd0, 16'hFFFF, 16'd5);
      send_item(bms_pkg::OP_PLAY, 3'd3, 16'd0, 16'd0);
      send_ticks(3);
      send_item(bms_pkg::OP_STOP, 3'd0, 16'd0, 16'd0);
      configure(8'd1, 24'd1000);
      send_item(bms_pkg::OP_TONE, 3'd0, 16'hFFFF, 16'd1);
      send_item(bms_pkg::OP_TONE, 3'd0, 16'd500, 16'd1);
      send_item(bms_pkg::OP_TONE, 3'd0, 16'd3, 16'd1);
      send_item(bms_pkg::OP_PLAY, 3'd2, 16'd0, 16'd0);
      send_ticks(12);
   endtask

   // Mostly complete melodies and raw tones followed by their ticks, some cut short,
   // with stops and a share of arbitrary items mixed in.
   task automatic run_mixed_traffic(input int count);
      int stop_at;
      int kind;
      int span;
      logic [bms_pkg::MELODY_WIDTH-1:0] melody;
      logic [bms_pkg::FREQ_WIDTH-1:0]   freq;
      logic [bms_pkg::TIME_WIDTH-1:0]   ms;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            melody = any_melody();
            if (melody >= bms_pkg::MELODY_COUNT && $urandom_range(0, 3) != 0)
               melody = melody - 3'd4;
            span = tune_units(melody) * unit_ms_cfg;
            if (span > 80) span = 80;
            if ($urandom_range(0, 3) == 0) span = $urandom_range(0, span);
            else span = span + $urandom_range(0, 3);
            send_item(bms_pkg::OP_PLAY, melody, any16(), any16());
            send_ticks(span);
         end else if (kind < 8) begin
            case ($urandom_range(0, 3))
               0: freq = 16'd0;
               1: freq = pick16(100, 2000);
               2: freq = any16();
               default: freq = pick16(1, 40);
            endcase
            ms = ($urandom_range(0, 7) == 0) ? any16() : pick16(0, 30);
            span = (ms > 60) ? 60 : ms;
            send_item(bms_pkg::OP_TONE, any_melody(), freq, ms);
            send_ticks(span + $urandom_range(0, 2));
         end else if (kind == 8) begin
            send_item(bms_pkg::OP_STOP, any_melody(), any16(), any16());
            send_ticks($urandom_range(0, 2));
         end else begin
            repeat ($urandom_range(1, 6)) send_item(any_op(), any_melody(), any16(), any16());
         end
      end
   endtask

   // The consumer holds off while requests keep coming, so the input has to stall.
   task automatic test_output_backpressure();
      wait_drained();
      holdoff_request = LONG_HOLDOFF;
      repeat (12)
         send_item(bms_pkg::OP_TONE, any_melody(), pick16(200, 3000), pick16(0, 20));
      wait_drained();
   endtask

   // The sender stops in the middle of a melody until every result is back.
   task automatic test_drain_pause();
      send_item(bms_pkg::OP_PLAY, 3'd1, 16'd0, 16'd0);
      send_ticks(5);
      wait_drained();
      send_ticks(20);
      send_item(bms_pkg::OP_STOP, 3'd0, 16'd0, 16'd0);
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_op = bms_pkg::OP_TICK;
      req_melody_index = '0;
      req_tone_freq_hz = '0;
      req_tone_duration_ms = '0;
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_melodies();
      test_directed_tones();
      test_register_extremes();

      configure(8'd1, 24'd1000000);
      run_mixed_traffic(300);
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      configure(8'd2, 24'd16000000);
      run_mixed_traffic(250);
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      configure(8'd255, 24'd1000000);
      run_mixed_traffic(150);
      configure(8'd1, 24'd1000);
      run_mixed_traffic(200);
      test_output_backpressure();
      test_drain_pause();
      configure(8'd3, 24'd1000000);
      run_mixed_traffic(200);
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      run_mixed_traffic(400);

      wait_drained();
      repeat (30) @(posedge clock);
      if (status_q.size() != 0) flag_mismatch("results never delivered", status_q.size(), 0);
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
